FILE: sv/btxq_pkg.sv
package btxq_pkg;

  // Command transaction as presented on the input channel.
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key;
    logic [31:0] bound;
  } btxq_in_t;

  // Result transaction as presented on the output channel.
  typedef struct packed {
    logic [15:0] count;
    logic [31:0] xor_value;
    logic [1:0]  status;
  } btxq_out_t;

  // Operation codes.
  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_ERASE  = 3'd1;
  localparam logic [2:0] FN_LESS   = 3'd2;
  localparam logic [2:0] FN_ATMOST = 3'd3;
  localparam logic [2:0] FN_ABOVE  = 3'd4;
  localparam logic [2:0] FN_MAX    = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

endpackage

FILE: sv/btxq_node_ram.sv
module btxq_node_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: sv/binary_trie_xor_query.sv
// Unsupported codes, a full count, an empty-set maximum or an oversized bound give
// the result in the cycle after start; counts and maximum walk the trie before answering.
// Insert and erase walk the trie once and then, unless refused, walk it again to write.
// Throughput: one transaction at a time, one node level per cycle through the node memory;
// a new start is taken in the cycle its predecessor's result is strobed. Results cannot stall.
// Reset (synchronous, rst_n low) empties the set at once; no clearing pass is needed.
module binary_trie_xor_query #(
  parameter int KEY_BITS   = 32,
  parameter int NODE_POOL  = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  btxq_pkg::btxq_in_t   in_data,
  output logic                 busy,
  output logic                 out_valid,
  output btxq_pkg::btxq_out_t  out_data
);
  import btxq_pkg::*;

  localparam int AW = $clog2(NODE_POOL);
  localparam int LW = $clog2(KEY_BITS);
  localparam int NW = AW + 1;
  localparam int SW = AW + 8;
  localparam int EW = 2 * AW + COUNT_BITS;
  localparam logic [LW-1:0] TOP_LVL = LW'(KEY_BITS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [1:0][AW-1:0]    lnk;
  } node_t;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_UPD, S_GROW} state_t;

  state_t                state_r, state_nxt;
  logic [2:0]            func_r, func_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [KEY_BITS-1:0]   bnd_r, bnd_nxt;
  logic [LW-1:0]         lvl_r, lvl_nxt;
  logic [COUNT_BITS-1:0] less_r, less_nxt;
  logic [KEY_BITS-1:0]   acc_r, acc_nxt;
  logic [1:0][AW-1:0]    ca_r;
  logic [1:0][AW-1:0]    root_r, root_nxt;
  logic [NW-1:0]         nf_r, nf_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic                  out_valid_r, out_valid_nxt;
  btxq_out_t             out_data_r, out_data_nxt;

  // Node memory interface.
  node_t              rd [2];
  node_t              wdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [1:0][AW-1:0] raddr;

  btxq_node_ram #(.WIDTH(EW), .DEPTH(NODE_POOL)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr0(raddr[0]),
    .raddr1(raddr[1]),
    .rdata0(rd[0]),
    .rdata1(rd[1])
  );

  // Per-level view of the two children of the current node.
  logic                  kb, bb, nb, side, takealt, go_ok, wide_c;
  logic [LW-1:0]         lvl_dn;
  logic [1:0]            vld;
  logic [COUNT_BITS-1:0] cnt_c [2];
  logic [COUNT_BITS-1:0] add_c, less_sum;
  logic [KEY_BITS-1:0]   acc_set;

  assign kb     = key_r[lvl_r];
  assign bb     = bnd_r[lvl_r];
  assign lvl_dn = lvl_r - 1'b1;
  assign nb     = key_r[lvl_dn];
  assign wide_c = (in_data.bound >> KEY_BITS) != '0;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      vld[i]   = ca_r[i] != '0;
      cnt_c[i] = vld[i] ? rd[i].cnt : '0;
    end
  end

  // Direction of the walk for the operation in hand.
  always_comb begin
    side    = kb;
    add_c   = '0;
    takealt = 1'b0;
    case (func_r) inside
      FN_LESS, FN_ATMOST, FN_ABOVE: begin
        side  = bb ? ~kb : kb;
        add_c = bb ? cnt_c[kb] : '0;
      end
      FN_MAX: begin
        takealt = vld[~kb] && (cnt_c[~kb] != '0);
        side    = takealt ? ~kb : kb;
      end
      default: begin
        side = kb;
      end
    endcase
  end

  assign go_ok    = vld[side];
  assign less_sum = less_r + add_c;
  assign acc_set  = acc_r | (takealt ? (KEY_BITS'(1) << lvl_r) : '0);

  // Count result, either for an oversized bound at start or at the end of the walk.
  logic                   in_idle;
  logic [2:0]             fin_func;
  logic [COUNT_BITS-1:0]  fin_less, fin_exact, atmost_c, cnt_res;
  logic [COUNT_BITS+15:0] cnt_wide;
  logic [KEY_BITS+31:0]   xor_wide;
  logic [SW-1:0]          pool_need;

  assign in_idle   = state_r == S_IDLE;
  assign fin_func  = in_idle ? in_data.func : func_r;
  assign fin_less  = in_idle ? total_r : less_sum;
  assign fin_exact = (!in_idle && go_ok && lvl_r == '0) ? cnt_c[side] : '0;
  assign atmost_c  = fin_less + fin_exact;

  always_comb begin
    case (fin_func)
      FN_LESS:   cnt_res = fin_less;
      FN_ATMOST: cnt_res = atmost_c;
      default:   cnt_res = total_r - atmost_c;
    endcase
  end

  assign cnt_wide  = {16'b0, cnt_res};
  assign xor_wide  = {32'b0, acc_set};
  assign pool_need = SW'(nf_r) + SW'(lvl_r) + SW'(1);

  // Sequencer: next state, memory access and result formation.
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    bnd_nxt       = bnd_r;
    lvl_nxt       = lvl_r;
    less_nxt      = less_r;
    acc_nxt       = acc_r;
    root_nxt      = root_r;
    nf_nxt        = nf_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    raddr         = root_r;
    we            = 1'b0;
    waddr         = ca_r[kb];
    wdata         = rd[kb];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt     = in_data.func;
          key_nxt      = in_data.key[KEY_BITS-1:0];
          bnd_nxt      = in_data.bound[KEY_BITS-1:0];
          lvl_nxt      = TOP_LVL;
          less_nxt     = '0;
          acc_nxt      = '0;
          out_data_nxt = '0;
          unique case (in_data.func) inside
            FN_INSERT: begin
              if (total_r == CNT_MAX) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_FULL;
              end else begin
                state_nxt = S_WALK;
              end
            end
            FN_ERASE: begin
              state_nxt = S_WALK;
            end
            FN_LESS, FN_ATMOST, FN_ABOVE: begin
              if (wide_c) begin
                out_valid_nxt      = 1'b1;
                out_data_nxt.count = cnt_wide[15:0];
              end else begin
                state_nxt = S_WALK;
              end
            end
            FN_MAX: begin
              if (total_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        out_data_nxt = '0;
        if (!go_ok || lvl_r == '0) begin
          // The walk ends: missing child or leaf level reached.
          state_nxt = S_IDLE;
          case (func_r) inside
            FN_INSERT: begin
              if (!go_ok && pool_need > SW'(NODE_POOL)) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_FULL;
              end else if (root_r[key_r[TOP_LVL]] == '0) begin
                root_nxt[key_r[TOP_LVL]] = nf_r[AW-1:0];
                lvl_nxt   = TOP_LVL;
                state_nxt = S_GROW;
              end else begin
                lvl_nxt   = TOP_LVL;
                state_nxt = S_UPD;
              end
            end
            FN_ERASE: begin
              if (!go_ok || cnt_c[side] == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_ABSENT;
              end else begin
                lvl_nxt   = TOP_LVL;
                state_nxt = S_UPD;
              end
            end
            FN_MAX: begin
              out_valid_nxt          = 1'b1;
              out_data_nxt.xor_value = xor_wide[31:0];
            end
            default: begin
              out_valid_nxt      = 1'b1;
              out_data_nxt.count = cnt_wide[15:0];
            end
          endcase
        end else begin
          lvl_nxt  = lvl_dn;
          less_nxt = less_sum;
          acc_nxt  = acc_set;
          raddr    = rd[side].lnk;
        end
      end

      S_UPD: begin
        // Rewrite the path node with its count moved by one.
        we           = 1'b1;
        out_data_nxt = '0;
        wdata.cnt    = (func_r == FN_INSERT) ? rd[kb].cnt + 1'b1 : rd[kb].cnt - 1'b1;
        if (func_r == FN_INSERT && lvl_r != '0 && rd[kb].lnk[nb] == '0) begin
          wdata.lnk[nb] = nf_r[AW-1:0];
          lvl_nxt       = lvl_dn;
          state_nxt     = S_GROW;
        end else if (lvl_r == '0) begin
          total_nxt     = (func_r == FN_INSERT) ? total_r + 1'b1 : total_r - 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          lvl_nxt = lvl_dn;
          raddr   = rd[kb].lnk;
        end
      end

      S_GROW: begin
        // Allocate a fresh node for each remaining level, chained to the next one.
        we           = 1'b1;
        waddr        = nf_r[AW-1:0];
        wdata.cnt    = COUNT_BITS'(1);
        wdata.lnk    = '0;
        nf_nxt       = nf_r + 1'b1;
        out_data_nxt = '0;
        if (lvl_r == '0) begin
          total_nxt     = total_r + 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          wdata.lnk[nb] = nf_nxt[AW-1:0];
          lvl_nxt       = lvl_dn;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      nf_r        <= NW'(1);
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      nf_r        <= nf_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      func_r      <= func_nxt;
      key_r       <= key_nxt;
      bnd_r       <= bnd_nxt;
      lvl_r       <= lvl_nxt;
      less_r      <= less_nxt;
      acc_r       <= acc_nxt;
      ca_r        <= raddr;
      out_data_r  <= out_data_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result is strobed only once the sequencer is back at rest.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobed while busy");

  // An accepted transaction either runs or answers at once.
  a_start_acts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("transaction dropped");

  // Allocation never runs past the node pool.
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GROW |-> nf_r < NW'(NODE_POOL)) else $error("node pool overrun");

  // The update walk only follows paths proven present by the first walk.
  a_path_present: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> ca_r[kb] != '0) else $error("update walk left the trie");

endmodule

FILE: dv/btxq_checker.sv
// Watches both channels of the trie, predicts every result and compares it.
module btxq_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  btxq_pkg::btxq_in_t  in_data,
  input  logic                out_valid,
  input  btxq_pkg::btxq_out_t out_data,
  output int                  errors,
  output int                  pending,
  output int                  results_seen,
  output int                  full_seen,
  output int                  absent_seen
);
  import btxq_pkg::*;

  localparam int          KEY_W     = 32;
  localparam int unsigned POOL_SIZE = 4096;
  localparam int unsigned CNT_MAX   = 65535;

  // Shadow copy of the trie: child links, per-node counts and allocation state.
  int unsigned child [POOL_SIZE][2];
  int unsigned hits  [POOL_SIZE];
  int unsigned free_node;
  int unsigned key_total;

  btxq_out_t   awaited_results[$];

  function automatic int unsigned link(int unsigned node, logic side);
    if (node >= POOL_SIZE) return 0;
    return child[node][side];
  endfunction

  function automatic int unsigned hits_at(int unsigned node);
    if (node >= POOL_SIZE) return 0;
    return hits[node];
  endfunction

  // Insert refuses when the total is saturated or the missing path does not fit.
  function automatic logic [1:0] trie_insert(logic [31:0] k);
    int unsigned cur;
    int unsigned need;
    int unsigned nx;
    if (key_total >= CNT_MAX) return ST_FULL;
    cur  = 0;
    need = 0;
    for (int b = KEY_W - 1; b >= 0; b--) begin
      nx = (cur == 0 && b != KEY_W - 1) ? 0 : link(cur, k[b]);
      if (nx == 0) begin
        need = b + 1;
        break;
      end
      cur = nx;
    end
    if (free_node + need > POOL_SIZE) return ST_FULL;
    cur = 0;
    for (int b = KEY_W - 1; b >= 0; b--) begin
      nx = link(cur, k[b]);
      if (nx == 0) begin
        nx = free_node;
        free_node++;
        child[nx][0] = 0;
        child[nx][1] = 0;
        hits[nx]     = 0;
        child[cur][k[b]] = nx;
      end
      cur = nx;
      hits[cur] = (hits[cur] + 1) & CNT_MAX;
    end
    key_total++;
    return ST_OK;
  endfunction

  // Erase first checks the whole path is present with a live leaf.
  function automatic logic [1:0] trie_erase(logic [31:0] k);
    int unsigned cur;
    cur = 0;
    for (int b = KEY_W - 1; b >= 0; b--) begin
      cur = link(cur, k[b]);
      if (cur == 0) return ST_ABSENT;
    end
    if (hits_at(cur) == 0) return ST_ABSENT;
    cur = 0;
    for (int b = KEY_W - 1; b >= 0; b--) begin
      cur = link(cur, k[b]);
      if (cur == 0 || cur >= POOL_SIZE) return ST_ABSENT;
      hits[cur]--;
    end
    key_total--;
    return ST_OK;
  endfunction

  // Keys whose XOR with k lies below bnd; exact receives those equal to bnd.
  function automatic longint unsigned xor_below(logic [31:0] k, logic [31:0] bnd,
                                                output longint unsigned exact);
    int unsigned     cur;
    int unsigned     nx;
    longint unsigned acc;
    cur = 0;
    acc = 0;
    for (int b = KEY_W - 1; b >= 0; b--) begin
      if (bnd[b]) begin
        acc += hits_at(link(cur, k[b]));
        nx = link(cur, !k[b]);
      end else begin
        nx = link(cur, k[b]);
      end
      if (nx == 0) begin
        exact = 0;
        return acc;
      end
      cur = nx;
    end
    exact = hits_at(cur);
    return acc;
  endfunction

  function automatic logic [1:0] xor_peak(logic [31:0] k, output logic [31:0] val);
    int unsigned cur;
    int unsigned alt;
    val = '0;
    if (key_total == 0) return ST_EMPTY;
    cur = 0;
    for (int b = KEY_W - 1; b >= 0; b--) begin
      alt = link(cur, !k[b]);
      if (alt != 0 && hits_at(alt) > 0) begin
        val[b] = 1'b1;
        cur    = alt;
      end else begin
        cur = link(cur, k[b]);
        if (cur == 0) break;
      end
    end
    return ST_OK;
  endfunction

  // Works out the result of one command and updates the shadow trie.
  function automatic btxq_out_t trie_result(btxq_in_t cmd);
    btxq_out_t       r;
    longint unsigned below;
    longint unsigned exact;
    longint unsigned upto;
    r = '0;
    case (cmd.func) inside
      FN_INSERT: r.status = trie_insert(cmd.key);
      FN_ERASE:  r.status = trie_erase(cmd.key);
      FN_LESS, FN_ATMOST, FN_ABOVE: begin
        below = xor_below(cmd.key, cmd.bound, exact);
        upto  = below + exact;
        if (cmd.func == FN_LESS) r.count = below[15:0];
        else if (cmd.func == FN_ATMOST) r.count = upto[15:0];
        else if (upto <= key_total) r.count = 16'(key_total - upto);
      end
      FN_MAX:    r.status = xor_peak(cmd.key, r.xor_value);
      default:   r = '0;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Results are compared before the command taken at the same edge is predicted.
  always @(posedge clk) begin
    btxq_out_t want;
    if (!rst_n) begin
      foreach (child[i]) begin
        child[i][0] = 0;
        child[i][1] = 0;
        hits[i]     = 0;
      end
      free_node    = 1;
      key_total    = 0;
      errors       = 0;
      results_seen = 0;
      full_seen    = 0;
      absent_seen  = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        results_seen++;
        if (out_data.status == ST_FULL) full_seen++;
        if (out_data.status == ST_ABSENT) absent_seen++;
        if (awaited_results.size() == 0) begin
          report("unexpected result status", 32'(out_data.status), 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.count != want.count)
            report("count", 32'(out_data.count), 32'(want.count));
          if (out_data.xor_value != want.xor_value)
            report("xor_value", out_data.xor_value, want.xor_value);
          if (out_data.status != want.status)
            report("status", 32'(out_data.status), 32'(want.status));
        end
      end
      if (start && !busy) awaited_results.push_back(trie_result(in_data));
    end
    pending = awaited_results.size();
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;
  import btxq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  btxq_in_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  btxq_out_t out_data;

  int          errors;
  int          pending;
  int          results_seen;
  int          full_seen;
  int          absent_seen;
  int          cycles = 0;
  int          idle_pct = 0;
  int          sent = 0;
  logic [31:0] key_pool[$];

  always #6 clk = ~clk;

  binary_trie_xor_query DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  btxq_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .errors      (errors),
    .pending     (pending),
    .results_seen(results_seen),
    .full_seen   (full_seen),
    .absent_seen (absent_seen)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one command, optionally after idle cycles, and holds it until taken.
  task automatic issue(btxq_in_t cmd);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    sent++;
    if (cmd.func == FN_INSERT && key_pool.size() < 300) key_pool.push_back(cmd.key);
  endtask

  task automatic issue_op(logic [2:0] f, logic [31:0] k, logic [31:0] b);
    btxq_in_t cmd;
    cmd.func  = f;
    cmd.key   = k;
    cmd.bound = b;
    issue(cmd);
  endtask

  function automatic logic [31:0] known_key();
    if (key_pool.size() == 0) return $urandom;
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  // Random command, biased towards keys already stored so erases and counts hit.
  task automatic issue_random(bit fill_only);
    int          pick;
    logic [2:0]  f;
    logic [31:0] k;
    logic [31:0] b;
    pick = fill_only ? 0 : $urandom_range(99);
    k    = ($urandom_range(99) < 50) ? known_key() : $urandom;
    case ($urandom_range(4))
      0:       b = known_key() ^ k;
      1:       b = $urandom_range(3) == 0 ? 32'hFFFF_FFFF : 32'h0;
      2:       b = (known_key() ^ k) + $urandom_range(2) - 1;
      default: b = $urandom;
    endcase
    if (pick < 35) begin
      f = FN_INSERT;
      if (fill_only || $urandom_range(99) < 70) k = $urandom;
    end else if (pick < 50) begin
      f = FN_ERASE;
      k = ($urandom_range(99) < 80) ? known_key() : $urandom;
    end else if (pick < 80) begin
      f = 3'($urandom_range(FN_LESS, FN_ABOVE));
    end else if (pick < 96) begin
      f = FN_MAX;
    end else begin
      f = 3'($urandom_range(6, 7));
    end
    issue_op(f, k, b);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty set, extreme keys, duplicates, exact bounds, unused codes.
    issue_op(FN_MAX,    32'h0,         32'h0);
    issue_op(FN_ERASE,  32'h1234_5678, 32'h0);
    issue_op(FN_LESS,   32'h0,         32'hFFFF_FFFF);
    issue_op(FN_INSERT, 32'h0,         32'h0);
    issue_op(FN_INSERT, 32'hFFFF_FFFF, 32'h0);
    issue_op(FN_INSERT, 32'h0,         32'h0);
    issue_op(FN_INSERT, 32'h8000_0000, 32'h0);
    issue_op(FN_LESS,   32'h0,         32'h0);
    issue_op(FN_ATMOST, 32'h0,         32'h0);
    issue_op(FN_ABOVE,  32'h0,         32'h0);
    issue_op(FN_LESS,   32'h0,         32'hFFFF_FFFF);
    issue_op(FN_ATMOST, 32'h0,         32'hFFFF_FFFF);
    issue_op(FN_ABOVE,  32'h0,         32'h8000_0000);
    issue_op(FN_ATMOST, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue_op(FN_MAX,    32'h0,         32'h0);
    issue_op(FN_MAX,    32'hFFFF_FFFF, 32'h0);
    issue_op(FN_ERASE,  32'h0,         32'h0);
    issue_op(FN_ERASE,  32'h0,         32'h0);
    issue_op(FN_ERASE,  32'h0,         32'h0);
    issue_op(3'd6,      $urandom,      $urandom);
    issue_op(3'd7,      $urandom,      $urandom);
    issue_op(FN_MAX,    32'h7FFF_FFFF, 32'h0);

    // Random phases with differing sender idling, then a pool-filling burst and a last random phase.
    idle_pct = 0;
    repeat (130) issue_random(1'b0);
    idle_pct = 71;
    repeat (120) issue_random(1'b0);
    idle_pct = 8;
    repeat (80) issue_random(1'b0);
    idle_pct = 0;
    repeat (60) issue_random(1'b1);
    repeat (60) issue_random(1'b0);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d commands and checked %0d results.", sent, results_seen);
    $display("Refused inserts seen: %0d, absent-key erases seen: %0d.", full_seen, absent_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
